[src/wll_pkg.sv]
`timescale 1ns / 1ps

package wll_pkg;

  localparam int unsigned MaxItems = 1024;
  localparam int unsigned AddrW    = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int unsigned CntW     = $clog2(MaxItems + 1);

  localparam int unsigned HeightW  = 16;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned SumW     = 26;

  localparam int unsigned InDataW  = ((HeightW + WeightW + 7) / 8) * 8;
  localparam int unsigned OutBitsW = 2 * SumW + 2;
  localparam int unsigned OutDataW = ((OutBitsW + 7) / 8) * 8;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic start;     // item beat taken, latch fields and clear accumulators
    logic set_drop;  // item beat arrived with store full
    logic issue;     // read store entry at scan index
    logic commit;    // write new entry, bump count, update maxima
    logic emit;      // load result register, clear sequence
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;
    logic last_item;
    logic out_free;
  } sts_t;

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                              input logic [WeightW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {{(SumW + 1 - WeightW){1'b0}}, b};
    return s[SumW] ? SumMax : s[SumW-1:0];
  endfunction

endpackage

[src/wll_ctrl.sv]
`timescale 1ns / 1ps

module wll_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  wll_pkg::sts_t sts_i,
  output wll_pkg::cmd_t cmd_o
);

  wll_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wll_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      wll_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (sts_i.full) begin
            cmd_o.set_drop = 1'b1;
            state_d = in_last_i ? wll_pkg::ST_EMIT : wll_pkg::ST_IDLE;
          end else if (sts_i.empty) begin
            state_d = wll_pkg::ST_COMMIT;
          end else begin
            state_d = wll_pkg::ST_SCAN;
          end
        end
      end
      wll_pkg::ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = wll_pkg::ST_DRAIN;
        end
      end
      // last read data is folded in during this cycle
      wll_pkg::ST_DRAIN: begin
        state_d = wll_pkg::ST_COMMIT;
      end
      wll_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = sts_i.last_item ? wll_pkg::ST_EMIT : wll_pkg::ST_IDLE;
      end
      wll_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = wll_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wll_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/wll_dp.sv]
`timescale 1ns / 1ps

module wll_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [wll_pkg::HeightW-1:0]   height_i,
  input  logic [wll_pkg::WeightW-1:0]   weight_i,
  input  logic                          last_i,
  input  wll_pkg::cmd_t                 cmd_i,
  output wll_pkg::sts_t                 sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wll_pkg::OutDataW-1:0]  out_data_o
);

  localparam int unsigned EntryW = wll_pkg::HeightW + 2 * wll_pkg::SumW;

  // item store: {height, inc sum, dec sum}
  logic [EntryW-1:0] mem_q [wll_pkg::MaxItems];
  logic [EntryW-1:0] rd_q;

  logic [wll_pkg::HeightW-1:0] h_q;
  logic [wll_pkg::WeightW-1:0] w_q;
  logic                        last_q;

  logic [wll_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [wll_pkg::AddrW-1:0] idx_q, idx_d;
  logic                      rd_vld_q;
  logic [wll_pkg::SumW-1:0]  up_q, up_d, down_q, down_d;
  logic [wll_pkg::SumW-1:0]  best_inc_q, best_inc_d, best_dec_q, best_dec_d;
  logic                      drop_q, drop_d;
  logic                      out_valid_q, out_valid_d;
  logic [wll_pkg::OutDataW-1:0] out_q;

  logic [wll_pkg::HeightW-1:0] rd_h;
  logic [wll_pkg::SumW-1:0]    rd_inc, rd_dec;
  logic [wll_pkg::SumW-1:0]    up_sum, down_sum;
  logic [wll_pkg::CntW-1:0]    idx_next;

  assign rd_h   = rd_q[EntryW-1 -: wll_pkg::HeightW];
  assign rd_inc = rd_q[2*wll_pkg::SumW-1 -: wll_pkg::SumW];
  assign rd_dec = rd_q[wll_pkg::SumW-1:0];

  assign up_sum   = wll_pkg::sat_add(up_q, w_q);
  assign down_sum = wll_pkg::sat_add(down_q, w_q);
  assign idx_next = {{(wll_pkg::CntW - wll_pkg::AddrW){1'b0}}, idx_q} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_q[cnt_q[wll_pkg::AddrW-1:0]] <= {h_q, up_sum, down_sum};
    end
    rd_q <= mem_q[idx_q];
    if (cmd_i.start) begin
      h_q    <= height_i;
      w_q    <= weight_i;
      last_q <= last_i;
    end
    if (cmd_i.emit) begin
      out_q <= {{(wll_pkg::OutDataW - wll_pkg::OutBitsW){1'b0}}, drop_q,
                (best_inc_q >= best_dec_q), best_dec_q, best_inc_q};
    end
  end

  always_comb begin
    idx_d       = idx_q;
    up_d        = up_q;
    down_d      = down_q;
    cnt_d       = cnt_q;
    best_inc_d  = best_inc_q;
    best_dec_d  = best_dec_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.start) begin
      idx_d  = '0;
      up_d   = '0;
      down_d = '0;
    end
    if (cmd_i.set_drop) begin
      drop_d = 1'b1;
    end
    if (cmd_i.issue) begin
      idx_d = idx_next[wll_pkg::AddrW-1:0];
    end
    // fold in the entry read in the previous cycle
    if (rd_vld_q) begin
      if (rd_h < h_q && rd_inc > up_q) begin
        up_d = rd_inc;
      end
      if (rd_h > h_q && rd_dec > down_q) begin
        down_d = rd_dec;
      end
    end
    if (cmd_i.commit) begin
      cnt_d = cnt_q + 1'b1;
      if (up_sum > best_inc_q) begin
        best_inc_d = up_sum;
      end
      if (down_sum > best_dec_q) begin
        best_dec_d = down_sum;
      end
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      cnt_d       = '0;
      best_inc_d  = '0;
      best_dec_d  = '0;
      drop_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      up_q        <= '0;
      down_q      <= '0;
      cnt_q       <= '0;
      best_inc_q  <= '0;
      best_dec_q  <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      rd_vld_q    <= cmd_i.issue;
      up_q        <= up_d;
      down_q      <= down_d;
      cnt_q       <= cnt_d;
      best_inc_q  <= best_inc_d;
      best_dec_q  <= best_dec_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.full      = (cnt_q == wll_pkg::CntW'(wll_pkg::MaxItems));
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.scan_last = (idx_next == cnt_q);
  assign sts_o.last_item = last_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/weighted_lis_lds_unit.sv]
`timescale 1ns / 1ps
// Sequencing: a stored item is taken in IDLE, scans the N items already stored in the sequence
// (skipped when N = 0), drains the last read and commits; a last item then loads the result once
// the result register is free. The scan reads one entry per cycle from the store's read port, and
// no new item is taken until the last one is through; an item dropped at full skips scan and commit.
// Reset: asynchronous, active low; clears control, count, maxima and drop flag. Store contents
// are not cleared and need no clearing pass.
module weighted_lis_lds_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [wll_pkg::InDataW-1:0]   s_axis_tdata,  // height[15:0], weight[31:16]
  input  logic                          s_axis_tlast,  // last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // increasing_total[25:0], decreasing_total[51:26], increasing_first[52], overflow[53], 0
  output logic [wll_pkg::OutDataW-1:0]  m_axis_tdata
);

  wll_pkg::cmd_t cmd;
  wll_pkg::sts_t sts;

  wll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wll_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .height_i    (s_axis_tdata[wll_pkg::HeightW-1:0]),
    .weight_i    (s_axis_tdata[wll_pkg::HeightW +: wll_pkg::WeightW]),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  a_busy_after_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !sts.full) |=> !s_axis_tready)
    else $error("input ready while an item is in work");

  a_no_commit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !sts.full)
    else $error("store written beyond capacity");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.emit))
    else $error("result beat without emit");

  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import wll_pkg::*;

  typedef struct packed {
    logic [SumW-1:0] up_total;
    logic [SumW-1:0] down_total;
    logic            up_first;
    logic            ovf;
  } totals_t;

  typedef struct {
    logic [HeightW-1:0] height;
    logic [WeightW-1:0] weight;
    logic               lst;
    bit                 typed;
    totals_t            want;
  } dir_row_t;

  localparam int unsigned NumDir = 19;
  localparam int unsigned HoldCycles = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // height[15:0], weight[31:16]
  logic                s_axis_tlast = 1'b0; // last
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // increasing_total[25:0], decreasing_total[51:26], increasing_first[52], overflow[53], 0
  logic [OutDataW-1:0] m_axis_tdata;

  // predictor copy of the sequence store
  logic [HeightW-1:0] seen_h    [MaxItems];
  logic [SumW-1:0]    seen_up   [MaxItems];
  logic [SumW-1:0]    seen_down [MaxItems];
  int unsigned        stored = 0;
  logic [SumW-1:0]    best_up = '0;
  logic [SumW-1:0]    best_down = '0;
  logic               overran = 1'b0;

  totals_t     totals_q [$];
  int unsigned totals_sent = 0;
  int unsigned errors = 0;
  bit          quiet = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;

  dir_row_t dir_rows [NumDir];

  weighted_lis_lds_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Chain sums for one taken item; returns the totals when it closes the sequence.
  task automatic take_item(input logic [HeightW-1:0] h, input logic [WeightW-1:0] w,
                           input logic lst, output bit got, output totals_t res);
    logic [SumW-1:0] up;
    logic [SumW-1:0] down;
    logic [SumW:0]   up_wide;
    logic [SumW:0]   down_wide;
    up = '0;
    down = '0;
    res = '0;
    if (stored < MaxItems) begin
      for (int unsigned j = 0; j < stored; j++) begin
        if (seen_h[j] < h && seen_up[j] > up) up = seen_up[j];
        if (seen_h[j] > h && seen_down[j] > down) down = seen_down[j];
      end
      up_wide = {1'b0, up} + {{(SumW + 1 - WeightW){1'b0}}, w};
      down_wide = {1'b0, down} + {{(SumW + 1 - WeightW){1'b0}}, w};
      up = up_wide[SumW] ? SumMax : up_wide[SumW-1:0];
      down = down_wide[SumW] ? SumMax : down_wide[SumW-1:0];
      seen_h[stored] = h;
      seen_up[stored] = up;
      seen_down[stored] = down;
      stored++;
      if (up > best_up) best_up = up;
      if (down > best_down) best_down = down;
    end else begin
      overran = 1'b1;
    end
    got = lst;
    if (lst) begin
      res.up_total = best_up;
      res.down_total = best_down;
      res.up_first = (best_up >= best_down);
      res.ovf = overran;
      stored = 0;
      best_up = '0;
      best_down = '0;
      overran = 1'b0;
    end
  endtask

  task automatic send_item(input logic [HeightW-1:0] h, input logic [WeightW-1:0] w,
                           input logic lst, input bit typed, input totals_t want);
    bit got;
    totals_t calc;
    while (!quiet && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= InDataW'({w, h});
    s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    take_item(h, w, lst, got, calc);
    if (got) begin
      totals_q.push_back(typed ? want : calc);
      totals_sent++;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (totals_q.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [SumW-1:0] want,
                             input logic [SumW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result side
  always @(posedge clk_i) begin
    totals_t got;
    totals_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.up_total = m_axis_tdata[SumW-1:0];
      got.down_total = m_axis_tdata[2*SumW-1:SumW];
      got.up_first = m_axis_tdata[2*SumW];
      got.ovf = m_axis_tdata[2*SumW+1];
      if (totals_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = totals_q.pop_front();
        check_field("increasing_total", want.up_total, got.up_total);
        check_field("decreasing_total", want.down_total, got.down_total);
        check_field("increasing_first", SumW'(want.up_first), SumW'(got.up_first));
        check_field("overflow", SumW'(want.ovf), SumW'(got.ovf));
      end
    end
  end

  // receiver: random stalls, one long hold while the sender keeps pushing
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        m_axis_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 19);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned n_items;
    int unsigned base_sent;
    int unsigned seq_len;
    int unsigned mode;
    int unsigned pick;
    bit          downward;
    logic [HeightW-1:0] base_h;
    logic [HeightW-1:0] h;
    logic [WeightW-1:0] w;

    dir_rows = '{
      '{16'h0000, 16'h0000, 1'b1, 1'b1, '{26'd0, 26'd0, 1'b1, 1'b0}},
      '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{26'd65535, 26'd65535, 1'b1, 1'b0}},
      // strictly rising run
      '{16'd1, 16'd10, 1'b0, 1'b0, '0},
      '{16'd2, 16'd20, 1'b0, 1'b0, '0},
      '{16'd3, 16'd30, 1'b1, 1'b1, '{26'd60, 26'd30, 1'b1, 1'b0}},
      // strictly falling run, decreasing side wins
      '{16'd3, 16'd5, 1'b0, 1'b0, '0},
      '{16'd2, 16'd5, 1'b0, 1'b0, '0},
      '{16'd1, 16'd5, 1'b1, 1'b1, '{26'd5, 26'd15, 1'b0, 1'b0}},
      // equal heights never chain
      '{16'd7, 16'd100, 1'b0, 1'b0, '0},
      '{16'd7, 16'd100, 1'b1, 1'b1, '{26'd100, 26'd100, 1'b1, 1'b0}},
      '{16'h0000, 16'hFFFF, 1'b0, 1'b0, '0},
      '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{26'd131070, 26'd65535, 1'b1, 1'b0}},
      '{16'hFFFF, 16'd1, 1'b0, 1'b0, '0},
      '{16'h0000, 16'd1, 1'b0, 1'b0, '0},
      '{16'hFFFF, 16'd1, 1'b1, 1'b0, '0},
      '{16'hAAAA, 16'h5555, 1'b0, 1'b0, '0},
      '{16'h5555, 16'hAAAA, 1'b0, 1'b0, '0},
      '{16'h8000, 16'h0001, 1'b0, 1'b0, '0},
      '{16'h7FFF, 16'hFFFE, 1'b1, 1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].height, dir_rows[i].weight, dir_rows[i].lst,
                dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    // fill the store, then two beats past capacity, the second one closing the sequence
    for (int unsigned i = 0; i < MaxItems + 2; i++) begin
      if ($urandom_range(3) == 0) h = HeightW'($urandom_range(65535));
      else h = HeightW'(i * 64 + $urandom_range(63));
      w = WeightW'($urandom_range(65535));
      send_item(h, w, i == MaxItems + 1, 1'b0, '0);
    end

    n_items = 0;
    base_sent = totals_sent;
    while (n_items < 130 || totals_sent - base_sent < 40) begin
      seq_len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
      mode = $urandom_range(3);
      base_h = HeightW'($urandom_range(65535));
      downward = 1'($urandom_range(1));
      for (int unsigned k = 0; k < seq_len; k++) begin
        quiet = (n_items < 30);
        if (n_items == 40) hold_go = 1'b1;
        case (mode)
          0: h = HeightW'($urandom_range(65535));
          1: h = HeightW'($urandom_range(7));
          2: begin
            pick = $urandom_range(3);
            h = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'h0001 :
                (pick == 2) ? 16'hFFFE : 16'hFFFF;
          end
          default: h = downward ? base_h - HeightW'(k * 97) : base_h + HeightW'(k * 97);
        endcase
        pick = $urandom_range(9);
        w = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : WeightW'($urandom_range(65535));
        send_item(h, w, k == seq_len - 1, 1'b0, '0);
        n_items++;
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (64) @(posedge clk_i);
    if (errors == 0 && totals_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
